// ===== src/serial_fifo_realtime_cmd_filter_defines.svh =====
// Assertion macros shared by the serial front end checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SERIAL_FIFO_REALTIME_CMD_FILTER_DEFINES_SVH
`define SERIAL_FIFO_REALTIME_CMD_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFRCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFRCF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sfrcf_pkg.sv =====
// Types and codes for the serial front end with real-time command filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfrcf_pkg;

    typedef logic [7:0] byte_t;

    localparam int MODE_W = 3;
    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_LINE_RX  = 3'd0;
    localparam mode_t MODE_HOST_RD  = 3'd1;
    localparam mode_t MODE_HOST_WR  = 3'd2;
    localparam mode_t MODE_TX_READY = 3'd3;
    localparam mode_t MODE_RX_FLUSH = 3'd4;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_STATUS_REPORT = 3'd0;
    localparam cfg_idx_t CFG_CYCLE_START   = 3'd1;
    localparam cfg_idx_t CFG_FEED_HOLD     = 3'd2;
    localparam cfg_idx_t CFG_RESET_CHAR    = 3'd3;

    localparam byte_t STATUS_REPORT_RST = 8'd63;
    localparam byte_t CYCLE_START_RST   = 8'd126;
    localparam byte_t FEED_HOLD_RST     = 8'd33;
    localparam byte_t RESET_CHAR_RST    = 8'd24;

    // Result flags carried from the access stage to the output register
    typedef struct packed {
        logic read_valid;
        logic line_valid;
        logic status_report_req;
        logic cycle_start_req;
        logic feed_hold_req;
        logic reset_req;
        logic rx_overflow;
        logic tx_refused;
        logic tx_pending;
    } flags_t;

endpackage

`default_nettype wire

// ===== src/serial_fifo_realtime_cmd_filter.sv =====
// One event per cycle is accepted while the output is not stalled by out_ready.
// Stage 1 updates the ring pointers and accesses the RX or TX memory (one port each
// for write and read, read data registered); stage 2 is the output register.
// Reset (async, active low) clears pointers and valids and sets the command
// registers to their defaults; memory contents are not cleared, only entries
// already written are ever read. Depends on sfrcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module serial_fifo_realtime_cmd_filter
    import sfrcf_pkg::*;
#(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,

    input  wire logic     cfg_we,
    input  wire cfg_idx_t cfg_index,
    input  wire byte_t    cfg_data,

    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire mode_t    mode,
    input  wire byte_t    byte_in,

    output logic          out_valid,
    input  wire logic     out_ready,
    output byte_t         read_data,
    output logic          read_valid,
    output byte_t         line_byte,
    output logic          line_valid,
    output logic          status_report_req,
    output logic          cycle_start_req,
    output logic          feed_hold_req,
    output logic          reset_req,
    output logic          rx_overflow,
    output logic          tx_refused,
    output logic          tx_pending
);

    localparam int RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
    localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);

    // Command registers
    byte_t status_char_reg, cycle_char_reg, hold_char_reg, reset_char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_char_reg <= STATUS_REPORT_RST;
            cycle_char_reg  <= CYCLE_START_RST;
            hold_char_reg   <= FEED_HOLD_RST;
            reset_char_reg  <= RESET_CHAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STATUS_REPORT: status_char_reg <= cfg_data;
                CFG_CYCLE_START:   cycle_char_reg  <= cfg_data;
                CFG_FEED_HOLD:     hold_char_reg   <= cfg_data;
                CFG_RESET_CHAR:    reset_char_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Memories
    byte_t rx_mem [RX_DEPTH];
    byte_t tx_mem [TX_DEPTH];

    logic [RX_PW-1:0] rx_wr_reg, rx_rd_reg, rx_wr_next, rx_rd_next, rx_wr_bump, rx_rd_bump;
    logic [TX_PW-1:0] tx_wr_reg, tx_rd_reg, tx_wr_next, tx_rd_next, tx_wr_bump, tx_rd_bump;

    logic   s1_valid_reg;
    flags_t s1_flags_reg, s1_flags_next;
    byte_t  rx_rdata_reg, tx_rdata_reg;

    logic   out_valid_reg;
    flags_t out_flags_reg;
    byte_t  read_data_reg, line_byte_reg;

    logic s1_adv, accept;
    logic rx_we, rx_re, tx_we, tx_re;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign rx_wr_bump = (rx_wr_reg == RX_LAST) ? '0 : rx_wr_reg + 1'b1;
    assign rx_rd_bump = (rx_rd_reg == RX_LAST) ? '0 : rx_rd_reg + 1'b1;
    assign tx_wr_bump = (tx_wr_reg == TX_LAST) ? '0 : tx_wr_reg + 1'b1;
    assign tx_rd_bump = (tx_rd_reg == TX_LAST) ? '0 : tx_rd_reg + 1'b1;

    always_comb
    begin
        s1_flags_next = '0;
        rx_wr_next    = rx_wr_reg;
        rx_rd_next    = rx_rd_reg;
        tx_wr_next    = tx_wr_reg;
        tx_rd_next    = tx_rd_reg;
        rx_we         = 1'b0;
        rx_re         = 1'b0;
        tx_we         = 1'b0;
        tx_re         = 1'b0;
        unique case (mode)
            MODE_LINE_RX:
            begin
                // Catch command bytes in priority order; they never reach the ring
                if (byte_in == status_char_reg)
                    s1_flags_next.status_report_req = 1'b1;
                else if (byte_in == cycle_char_reg)
                    s1_flags_next.cycle_start_req = 1'b1;
                else if (byte_in == hold_char_reg)
                    s1_flags_next.feed_hold_req = 1'b1;
                else if (byte_in == reset_char_reg)
                    s1_flags_next.reset_req = 1'b1;
                else if (rx_wr_bump != rx_rd_reg)
                begin
                    rx_we      = 1'b1;
                    rx_wr_next = rx_wr_bump;
                end
                else
                    s1_flags_next.rx_overflow = 1'b1;
            end
            MODE_HOST_RD:
            begin
                if (rx_rd_reg != rx_wr_reg)
                begin
                    rx_re                    = 1'b1;
                    rx_rd_next               = rx_rd_bump;
                    s1_flags_next.read_valid = 1'b1;
                end
            end
            MODE_HOST_WR:
            begin
                if (tx_wr_bump != tx_rd_reg)
                begin
                    tx_we      = 1'b1;
                    tx_wr_next = tx_wr_bump;
                end
                else
                    s1_flags_next.tx_refused = 1'b1;
            end
            MODE_TX_READY:
            begin
                if (tx_rd_reg != tx_wr_reg)
                begin
                    tx_re                    = 1'b1;
                    tx_rd_next               = tx_rd_bump;
                    s1_flags_next.line_valid = 1'b1;
                end
            end
            MODE_RX_FLUSH: rx_rd_next = rx_wr_reg;
            default: ;
        endcase
        s1_flags_next.tx_pending = (tx_rd_next != tx_wr_next);
    end

    // Memory ports: a read never targets the entry written in the same cycle,
    // since reads only cover entries between the pointers
    always_ff @(posedge clk)
    begin
        if (accept && rx_we)
            rx_mem[rx_wr_reg] <= byte_in;
        if (accept && rx_re)
            rx_rdata_reg <= rx_mem[rx_rd_reg];
        if (accept && tx_we)
            tx_mem[tx_wr_reg] <= byte_in;
        if (accept && tx_re)
            tx_rdata_reg <= tx_mem[tx_rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_reg    <= '0;
            rx_rd_reg    <= '0;
            tx_wr_reg    <= '0;
            tx_rd_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rx_wr_reg <= rx_wr_next;
                rx_rd_reg <= rx_rd_next;
                tx_wr_reg <= tx_wr_next;
                tx_rd_reg <= tx_rd_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_flags_reg <= s1_flags_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_flags_reg <= s1_flags_reg;
            read_data_reg <= s1_flags_reg.read_valid ? rx_rdata_reg : '0;
            line_byte_reg <= s1_flags_reg.line_valid ? tx_rdata_reg : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = read_data_reg;
    assign line_byte         = line_byte_reg;
    assign read_valid        = out_flags_reg.read_valid;
    assign line_valid        = out_flags_reg.line_valid;
    assign status_report_req = out_flags_reg.status_report_req;
    assign cycle_start_req   = out_flags_reg.cycle_start_req;
    assign feed_hold_req     = out_flags_reg.feed_hold_req;
    assign reset_req         = out_flags_reg.reset_req;
    assign rx_overflow       = out_flags_reg.rx_overflow;
    assign tx_refused        = out_flags_reg.tx_refused;
    assign tx_pending        = out_flags_reg.tx_pending;

endmodule

`default_nettype wire

// ===== src/sfrcf_checker.sv =====
// Port-level checks for the serial front end; bound to the top level below.
// Depends on sfrcf_pkg and serial_fifo_realtime_cmd_filter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_fifo_realtime_cmd_filter_defines.svh"

module sfrcf_checker
    import sfrcf_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire byte_t    read_data,
    input wire logic     read_valid,
    input wire byte_t    line_byte,
    input wire logic     line_valid,
    input wire logic     status_report_req,
    input wire logic     cycle_start_req,
    input wire logic     feed_hold_req,
    input wire logic     reset_req,
    input wire logic     rx_overflow,
    input wire logic     tx_refused
);

    logic [7:0] event_flags;

    assign event_flags = {read_valid, line_valid, status_report_req, cycle_start_req,
                          feed_hold_req, reset_req, rx_overflow, tx_refused};

    // One event raises at most one outcome flag
    `SFRCF_ASSERT_IMP(a_one_outcome, out_valid, $onehot0(event_flags), "several outcome flags")
    `SFRCF_ASSERT_IMP(a_read_zero, out_valid && !read_valid, read_data == 8'd0,
        "read_data nonzero without read_valid")
    `SFRCF_ASSERT_IMP(a_line_zero, out_valid && !line_valid, line_byte == 8'd0,
        "line_byte nonzero without line_valid")
    `SFRCF_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(read_data) && $stable(line_byte), "stalled result changed")

endmodule

bind serial_fifo_realtime_cmd_filter sfrcf_checker u_sfrcf_checker (.*);

`default_nettype wire
